// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg
// Constants shared by the periodic task tick scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int TASK_COUNT_W = 4;
    localparam int TASK_NUM_W   = 4;
    localparam int TICK_IDX_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TASK_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIODS     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXEC_TIMES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADLINES   = 3'd4;

    localparam logic POLICY_RM  = 1'b0;
    localparam logic POLICY_EDF = 1'b1;

endpackage

// ===== rtl/core/ptts_slot.sv =====
// ----------------------------------------------------------------------------
// ptts_slot
// State of one task slot: release, priority key and per-tick update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_slot
    import ptts_pkg::*;
#(
    parameter int TICK_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic                 i_restart,
    input  logic                 i_active,
    input  logic                 i_policy,
    input  logic                 i_run,
    input  logic [TICK_BITS-1:0] i_period,
    input  logic [TICK_BITS-1:0] i_exec_time,
    input  logic [TICK_BITS-1:0] i_deadline,
    output logic [TICK_BITS+2:0] o_key
);

    localparam int DL_W = TICK_BITS + 2;
    localparam logic [DL_W-1:0] DL_MIN = {1'b1, {(DL_W-1){1'b0}}};

    logic [TICK_BITS-1:0] r_work, n_work;
    logic [TICK_BITS-1:0] r_count, n_count;
    logic [DL_W-1:0]      r_dl, n_dl;

    logic [TICK_BITS-1:0] period_eff;
    logic [TICK_BITS-1:0] count_cur;
    logic [TICK_BITS-1:0] work_cur;
    logic [DL_W-1:0]      dl_cur;
    logic                 released;
    logic                 ready;
    logic [DL_W-1:0]      metric;

    always_comb begin
        period_eff = (i_period == '0) ? TICK_BITS'(1) : i_period;
        count_cur  = i_restart ? '0 : r_count;
        released   = (count_cur == '0);
        if (released) begin
            work_cur = i_exec_time;
            dl_cur   = {2'b00, i_deadline};
        end else begin
            work_cur = r_work;
            dl_cur   = r_dl;
        end
        ready  = i_active && (work_cur != '0);
        metric = (i_policy == POLICY_EDF) ? {~dl_cur[DL_W-1], dl_cur[DL_W-2:0]}
                                          : {2'b00, period_eff};
        o_key  = {~ready, metric};

        if (i_active) begin
            n_work  = work_cur - TICK_BITS'(i_run);
            n_count = (released ? period_eff : count_cur) - TICK_BITS'(1);
            n_dl    = (dl_cur != DL_MIN) ? dl_cur - DL_W'(1) : dl_cur;
        end else begin
            n_work  = '0;
            n_count = '0;
            n_dl    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work  <= '0;
            r_count <= '0;
            r_dl    <= '0;
        end else if (i_step) begin
            r_work  <= n_work;
            r_count <= n_count;
            r_dl    <= n_dl;
        end
    end

endmodule

// ===== rtl/core/ptts_select.sv =====
// ----------------------------------------------------------------------------
// ptts_select
// Compare tree that finds the ready slot with the smallest key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_select
    import ptts_pkg::*;
#(
    parameter int MAX_SLOTS = 8,
    parameter int KEY_W     = 11,
    parameter int IDX_W     = 3
) (
    input  logic [MAX_SLOTS-1:0][KEY_W-1:0] i_keys,
    output logic                            o_found,
    output logic [IDX_W-1:0]                o_index
);

    localparam int NP    = 1 << IDX_W;
    localparam int NODES = 2 * NP - 1;
    localparam int NW    = KEY_W + IDX_W;

    logic [NW-1:0] node [NODES];

    // The slot index is the low part of each key, so ties go to the lowest slot.
    always_comb begin
        for (int i = 0; i < NP; i++) begin
            if (i < MAX_SLOTS) begin
                node[NP-1+i] = {i_keys[i], IDX_W'(i)};
            end else begin
                node[NP-1+i] = '1;
            end
        end
        for (int k = NP - 2; k >= 0; k--) begin
            node[k] = (node[2*k+1] <= node[2*k+2]) ? node[2*k+1] : node[2*k+2];
        end
        o_found = ~node[0][NW-1];
        o_index = node[0][IDX_W-1:0];
    end

endmodule

// ===== rtl/core/periodic_task_tick_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_core
// Rate monotonic / earliest deadline first scheduler, one tick per item.
// ----------------------------------------------------------------------------
// Each input item is one scheduler tick carrying a restart flag. The block
// releases due task slots, picks the ready slot with the shortest period or
// nearest deadline (lowest slot wins ties), runs it for one tick and returns
// one result item with the slot number, or idle, and the tick index.
// The input channel (i_in_valid / o_in_stall) feeds an input register; the
// slot update and selection sit between it and the result register, which
// drives the output channel (o_out_valid / i_out_stall).
// An accepted item passes the input register and then the result register;
// a receiver stall can hold it in either. Throughput is one item per cycle
// while the receiver does not stall, set by the slot update and compare tree.
// When the receiver stalls, the result holds and one more item can be taken
// into the input register before o_in_stall rises.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data
// by the user only while idle; the block does not enforce it. Reset clears all
// slot state, tick count and pipeline and sets defaults with one task in use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_task_tick_scheduler_core
    import ptts_pkg::*;
#(
    parameter int MAX_SLOTS = 8,
    parameter int TICK_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_restart,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_ran_task,
    output logic [TASK_NUM_W-1:0]   o_task_number,
    output logic [TICK_IDX_W-1:0]   o_tick_index
);

    localparam int KEY_W = TICK_BITS + 3;
    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic                    r_policy;
    logic [TASK_COUNT_W-1:0] r_task_count;
    logic [CFG_DATA_W-1:0]   r_periods;
    logic [CFG_DATA_W-1:0]   r_exec_times;
    logic [CFG_DATA_W-1:0]   r_deadlines;

    logic                    r_s1_valid;
    logic                    r_s1_restart;
    logic                    r_out_valid;
    logic                    r_ran_task;
    logic [TASK_NUM_W-1:0]   r_task_number;
    logic [TICK_IDX_W-1:0]   r_tick_out;
    logic [TICK_IDX_W-1:0]   r_tick;
    logic [TICK_IDX_W-1:0]   tick_cur;

    logic                    advance;
    logic                    step;
    logic                    in_accept;

    logic [MAX_SLOTS-1:0][KEY_W-1:0] keys;
    logic [MAX_SLOTS-1:0]            active;
    logic [MAX_SLOTS-1:0]            run;
    logic                            sel_found;
    logic [IDX_W-1:0]                sel_index;

    assign advance   = !r_out_valid || !i_out_stall;
    assign step      = r_s1_valid && advance;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept = i_in_valid && !o_in_stall;
    assign tick_cur  = r_s1_restart ? '0 : r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy     <= POLICY_RM;
            r_task_count <= TASK_COUNT_W'(1);
            r_periods    <= '0;
            r_exec_times <= '0;
            r_deadlines  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_POLICY_MODE: r_policy     <= i_cfg_data[0];
                CFG_TASK_COUNT:  r_task_count <= i_cfg_data[TASK_COUNT_W-1:0];
                CFG_PERIODS:     r_periods    <= i_cfg_data;
                CFG_EXEC_TIMES:  r_exec_times <= i_cfg_data;
                CFG_DEADLINES:   r_deadlines  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    genvar s;
    generate
        for (s = 0; s < MAX_SLOTS; s++) begin : g_slot
            localparam int POS = s * TICK_BITS;
            logic [TICK_BITS-1:0] period_lane;
            logic [TICK_BITS-1:0] exec_lane;
            logic [TICK_BITS-1:0] dl_lane;

            if (POS >= CFG_DATA_W) begin : g_empty
                assign period_lane = '0;
                assign exec_lane   = '0;
                assign dl_lane     = '0;
            end else begin : g_lane
                assign period_lane = TICK_BITS'(r_periods >> POS);
                assign exec_lane   = TICK_BITS'(r_exec_times >> POS);
                assign dl_lane     = TICK_BITS'(r_deadlines >> POS);
            end

            assign active[s] = (32'(r_task_count) > s);
            assign run[s]    = sel_found && (sel_index == IDX_W'(s));

            ptts_slot #(
                .TICK_BITS (TICK_BITS)
            ) u_slot (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_step      (step),
                .i_restart   (r_s1_restart),
                .i_active    (active[s]),
                .i_policy    (r_policy),
                .i_run       (run[s]),
                .i_period    (period_lane),
                .i_exec_time (exec_lane),
                .i_deadline  (dl_lane),
                .o_key       (keys[s])
            );
        end
    endgenerate

    ptts_select #(
        .MAX_SLOTS (MAX_SLOTS),
        .KEY_W     (KEY_W),
        .IDX_W     (IDX_W)
    ) u_select (
        .i_keys  (keys),
        .o_found (sel_found),
        .o_index (sel_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (step) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
            if (step) begin
                r_tick <= tick_cur + TICK_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_restart <= i_restart;
        end
        if (step) begin
            r_ran_task    <= sel_found;
            r_task_number <= sel_found ? TASK_NUM_W'(sel_index) + TASK_NUM_W'(1) : '0;
            r_tick_out    <= tick_cur;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ran_task    = r_ran_task;
    assign o_task_number = r_task_number;
    assign o_tick_index  = r_tick_out;

    `ASSERT_IMPL(a_sel_active, i_clk, i_rst_n, step && sel_found, active[sel_index])
    `ASSERT_NEXT(a_restart_tick, i_clk, i_rst_n, step && r_s1_restart, o_tick_index == '0)
    `ASSERT_NEXT(a_tick_inc, i_clk, i_rst_n, step && !r_s1_restart,
                 r_tick == $past(r_tick) + TICK_IDX_W'(1))
    `ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, r_s1_valid && r_out_valid && i_out_stall,
                 r_s1_valid)

endmodule
